[rtl/tcst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared types and codes of the timed command schedule table.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int POS_W   = 8;     // cell position field, covers depths up to 256
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 6;     // entry count field of a result
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 3;

    // opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_SHOOT   = 3'd2;
    localparam logic [2:0] KIND_VIDEO   = 3'd3;
    localparam logic [2:0] KIND_DISCARD = 3'd4;
    localparam logic [2:0] KIND_NONE    = 3'd5;
    localparam logic [2:0] KIND_STATUS  = 3'd6;

    // entry command codes
    localparam logic [7:0] CODE_SHOOT = 8'h03;
    localparam logic [7:0] CODE_VIDEO = 8'h04;
    localparam logic [7:0] VIDEO_TAIL = 8'd30;

    // status report clears busy only with at least this many payload bytes
    localparam logic [7:0] STATUS_MIN_LEN = 8'd12;
    localparam logic [7:0] STATUS_IDLE    = 8'd0;

    typedef struct packed {
        logic [15:0]       second;
        logic [15:0]       first;
        logic [7:0]        command;
        logic [TIME_W-1:0] epoch;
    } entry_t;

    typedef struct packed {
        logic              shift;     // every cell takes its upper neighbor
        logic              push;      // head beat goes back in at push_pos
        logic [POS_W-1:0]  push_pos;
        logic              load;      // new entry written at load_pos
        logic [POS_W-1:0]  load_pos;
        entry_t            new_entry;
        logic [TIME_W-1:0] now;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SINGLE,
        ST_RUN
    } state_t;

endpackage : tcst_pkg
`default_nettype wire

[rtl/tcst_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcst_cell
// One slot of the schedule chain: holds an entry, shifts toward the head and
// flags whether its entry is due at the current time.
// ----------------------------------------------------------------------------
module tcst_cell #(
    parameter int IDX = 0
) (
    input  wire logic               aclk,
    input  wire tcst_pkg::cell_ctrl_t ctrl,
    input  wire tcst_pkg::entry_t   nbr_in,
    input  wire tcst_pkg::entry_t   head_in,
    output tcst_pkg::entry_t        entry_out,
    output logic                    due_out
);
    import tcst_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load && (ctrl.load_pos == MY_POS)) begin
            entry_next = ctrl.new_entry;
        end else if (ctrl.shift) begin
            // kept head entry goes back in at the tail of the queue
            entry_next = (ctrl.push && (ctrl.push_pos == MY_POS)) ? head_in : nbr_in;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign due_out   = (entry_reg.epoch <= ctrl.now);

endmodule : tcst_cell
`default_nettype wire

[rtl/timed_command_schedule_table_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// timed_command_schedule_table_top
// Table of timed commands in insertion order, kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one command beat: add an entry, run due entries at
//   now_time, or a status report. m_ channel gives the result beats; tlast
//   marks the last result of an input beat, tuser carries the result kind.
//   Add and status beats give one result each; so does a run with no due
//   entry, with kind none. A run with due entries visits every held entry,
//   one per cycle unless a stalled output holds it, through the head of
//   the chain. Kept entries re-enter at the tail, so the table stays
//   compacted in order.
//   s_tready is high only while idle; a finished result may still wait in
//   the output register while the next beat is taken. While the receiver
//   stalls, a run holds at any entry that has a result to emit.
//   Reset empties the table and clears busy; entry contents are not cleared.
// ----------------------------------------------------------------------------
module timed_command_schedule_table_top #(
    parameter int TABLE_DEPTH = tcst_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // opcode, now_time, entry_epoch, entry_command, entry_first_param,
    // entry_second_param, status_mode, status_length, zero fill
    input  wire logic [tcst_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cmd_byte_zero, cmd_byte_one, cmd_byte_two, log_value, due_flag,
    // busy_flag, entry_count
    output logic [tcst_pkg::M_DATA_W-1:0]      m_tdata,
    // result_kind
    output logic [tcst_pkg::M_USER_W-1:0]      m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import tcst_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [1:0]        op_reg;
    logic [TIME_W-1:0] now_reg;
    entry_t            new_entry_reg;
    logic [7:0]        mode_reg;
    logic [7:0]        len_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              busy_reg, busy_next;
    logic              due_reg, due_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        kind_reg, kind_next;
    logic [7:0]        b0_reg, b0_next;
    logic [7:0]        b1_reg, b1_next;
    logic [7:0]        b2_reg, b2_next;
    logic [15:0]       log_reg, log_next;
    logic              odue_reg, odue_next;
    logic              obusy_reg, obusy_next;
    logic [CNT_W-1:0]  ocount_reg, ocount_next;
    logic              last_reg, last_next;

    // ------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------
    cell_ctrl_t           ctrl;
    entry_t               ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] le_vec;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        entry_t nbr;
        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign nbr = ent[0];
        end else begin : g_mid
            assign nbr = ent[i + 1];
        end
        tcst_cell #(
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .nbr_in    (nbr),
            .head_in   (ent[0]),
            .entry_out (ent[i]),
            .due_out   (le_vec[i])
        );
    end

    // due entries among the held ones, and among those behind the head
    logic any_due;
    logic more_due;
    always_comb begin
        any_due  = 1'b0;
        more_due = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (le_vec[i] && (CNT_W'(i) < count_reg)) begin
                any_due = 1'b1;
                if (i > 0) begin
                    more_due = 1'b1;
                end
            end
        end
    end

    logic out_free;
    logic accept;
    logic head_due;
    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign head_due = le_vec[0];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                unique case (op_reg)
                    OP_ADD, OP_STATUS: state_next = ST_SINGLE;
                    OP_RUN:            state_next = any_due ? ST_RUN : ST_SINGLE;
                    default:           state_next = ST_IDLE;
                endcase
            end
            ST_SINGLE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (rem_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath control and result formation
    // ------------------------------------------------------------------
    always_comb begin
        logic emit;
        emit = 1'b0;

        s_tready = (state_reg == ST_IDLE);

        ctrl           = '0;
        ctrl.now       = now_reg;
        ctrl.new_entry = new_entry_reg;
        ctrl.push_pos  = POS_W'(count_reg - ONE_CNT);
        ctrl.load_pos  = POS_W'(count_reg);

        count_next = count_reg;
        rem_next   = rem_reg;
        busy_next  = busy_reg;
        due_next   = due_reg;

        kind_next   = kind_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        log_next    = log_reg;
        odue_next   = odue_reg;
        obusy_next  = obusy_reg;
        ocount_next = ocount_reg;
        last_next   = last_reg;

        unique case (state_reg)
            ST_IDLE: ;
            ST_CHECK: begin
                due_next = (count_reg != '0) && !busy_reg && any_due;
                rem_next = count_reg;
            end
            ST_SINGLE: begin
                if (out_free) begin
                    emit      = 1'b1;
                    b0_next   = '0;
                    b1_next   = '0;
                    b2_next   = '0;
                    log_next  = '0;
                    last_next = 1'b1;
                    unique case (op_reg)
                        OP_ADD: begin
                            if (count_reg >= FULL_CNT) begin
                                kind_next = KIND_FULL;
                            end else begin
                                kind_next  = KIND_ADDED;
                                ctrl.load  = 1'b1;
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        OP_STATUS: begin
                            kind_next = KIND_STATUS;
                            if ((len_reg >= STATUS_MIN_LEN) && (mode_reg == STATUS_IDLE)) begin
                                busy_next = 1'b0;
                            end
                        end
                        default: kind_next = KIND_NONE;
                    endcase
                end
            end
            ST_RUN: begin
                if ((rem_reg != '0) && (!head_due || out_free)) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - ONE_CNT;
                    if (head_due) begin
                        emit       = 1'b1;
                        count_next = count_reg - ONE_CNT;
                        busy_next  = 1'b1;
                        last_next  = !more_due;
                        log_next   = '0;
                        b0_next    = '0;
                        b1_next    = '0;
                        b2_next    = '0;
                        if (ent[0].command == CODE_SHOOT) begin
                            kind_next = KIND_SHOOT;
                            b0_next   = ent[0].first[7:0];
                            b1_next   = ent[0].second[7:0];
                            b2_next   = ent[0].second[15:8];
                            log_next  = ent[0].first;
                        end else if (ent[0].command == CODE_VIDEO) begin
                            kind_next = KIND_VIDEO;
                            b0_next   = ent[0].first[7:0];
                            b1_next   = ent[0].first[15:8];
                            b2_next   = VIDEO_TAIL;
                            log_next  = ent[0].first;
                        end else begin
                            kind_next = KIND_DISCARD;
                        end
                    end else begin
                        ctrl.push = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (emit) begin
            odue_next   = due_reg;
            obusy_next  = busy_next;
            ocount_next = count_next;
        end

        m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rem_reg     <= '0;
            busy_reg    <= 1'b0;
            due_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            busy_reg    <= busy_next;
            due_reg     <= due_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg                <= s_tdata[1:0];
            now_reg               <= s_tdata[33:2];
            new_entry_reg.epoch   <= s_tdata[65:34];
            new_entry_reg.command <= s_tdata[73:66];
            new_entry_reg.first   <= s_tdata[89:74];
            new_entry_reg.second  <= s_tdata[105:90];
            mode_reg              <= s_tdata[113:106];
            len_reg               <= s_tdata[121:114];
        end
        kind_reg   <= kind_next;
        b0_reg     <= b0_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        log_reg    <= log_next;
        odue_reg   <= odue_next;
        obusy_reg  <= obusy_next;
        ocount_reg <= ocount_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {COUNT_W'(ocount_reg), obusy_reg, odue_reg, log_reg,
                       b2_reg, b1_reg, b0_reg};

endmodule : timed_command_schedule_table_top
`default_nettype wire

[bench/tb_timed_command_schedule_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_command_schedule_table_top
// Self-checking bench for the timed command schedule table.
// Command beats go in on the s_ stream and are predicted by a model of the
// table kept here. Each result beat on the m_ stream is checked field by field
// against the oldest prediction. Both streams idle at random, and the output
// is held off for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_timed_command_schedule_table_top;
    import tcst_pkg::*;

    localparam int          DEPTH          = DEFAULT_TABLE_DEPTH;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          IDLE_PERCENT   = 38;
    localparam int          RANDOM_ITEMS   = 90;
    localparam logic [31:0] TIME_MAX       = 32'hFFFF_FFFF;

    // packed so that opcode lands in the lowest bits of s_tdata
    typedef struct packed {
        logic [5:0]  fill;
        logic [7:0]  len;
        logic [7:0]  mode;
        logic [15:0] second;
        logic [15:0] first;
        logic [7:0]  cmd;
        logic [31:0] epoch;
        logic [31:0] now;
        logic [1:0]  op;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] logv;
        logic        due;
        logic        busy;
        logic [5:0]  count;
        logic        last;
    } sched_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // table model
    entry_t         table_entries [DEPTH];
    int unsigned    table_held;
    logic           table_busy;
    sched_result_t  pending_results [$];

    int  mismatches = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    int  rx_hold_req = 0;
    int  rx_hold_seen = 0;
    int  rx_hold_left = 0;
    logic [31:0] sim_clock;

    timed_command_schedule_table_top #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    task automatic predict_table_step(input cmd_beat_t beat);
        sched_result_t produced [$];
        sched_result_t r;
        entry_t        e;
        logic          due;
        int unsigned   keep;
        int unsigned   total;

        due = 1'b0;
        if (table_held > 0 && !table_busy) begin
            for (int i = 0; i < table_held; i++)
                if (table_entries[i].epoch <= beat.now) due = 1'b1;
        end
        r = '0;
        r.due = due;
        case (beat.op)
            OP_ADD: begin
                if (table_held >= DEPTH) begin
                    r.kind = KIND_FULL;
                end else begin
                    table_entries[table_held] = '{second: beat.second, first: beat.first,
                                                  command: beat.cmd, epoch: beat.epoch};
                    table_held++;
                    r.kind = KIND_ADDED;
                end
                r.busy  = table_busy;
                r.count = table_held[5:0];
                produced.push_back(r);
            end
            OP_RUN: begin
                keep  = 0;
                total = table_held;
                for (int i = 0; i < total; i++) begin
                    e = table_entries[i];
                    if (e.epoch <= beat.now) begin
                        table_busy = 1'b1;
                        table_held--;
                        r = '0;
                        r.due = due;
                        if (e.command == CODE_SHOOT) begin
                            r.kind = KIND_SHOOT;
                            r.b0   = e.first[7:0];
                            r.b1   = e.second[7:0];
                            r.b2   = e.second[15:8];
                            r.logv = e.first;
                        end else if (e.command == CODE_VIDEO) begin
                            r.kind = KIND_VIDEO;
                            r.b0   = e.first[7:0];
                            r.b1   = e.first[15:8];
                            r.b2   = VIDEO_TAIL;
                            r.logv = e.first;
                        end else begin
                            r.kind = KIND_DISCARD;
                        end
                        r.busy  = table_busy;
                        r.count = table_held[5:0];
                        produced.push_back(r);
                    end else begin
                        table_entries[keep] = e;
                        keep++;
                    end
                end
                table_held = keep;
                if (produced.size() == 0) begin
                    r = '0;
                    r.due   = due;
                    r.kind  = KIND_NONE;
                    r.busy  = table_busy;
                    r.count = table_held[5:0];
                    produced.push_back(r);
                end
            end
            OP_STATUS: begin
                if (beat.len >= STATUS_MIN_LEN && beat.mode == STATUS_IDLE)
                    table_busy = 1'b0;
                r.kind  = KIND_STATUS;
                r.busy  = table_busy;
                r.count = table_held[5:0];
                produced.push_back(r);
            end
            default: ;  // unknown opcode: ignored
        endcase
        if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
        foreach (produced[i]) pending_results.push_back(produced[i]);
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_command(input cmd_beat_t beat);
        int gap;

        gap = 0;
        if (!tx_steady)
            while ($urandom_range(99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_table_step(beat);
    endtask

    // every field but the fill random, so the ones an opcode ignores still toggle
    function automatic cmd_beat_t random_beat(input logic [1:0] op);
        cmd_beat_t b;
        b.fill   = '0;
        b.len    = 8'($urandom);
        b.mode   = 8'($urandom);
        b.second = 16'($urandom);
        b.first  = 16'($urandom);
        b.cmd    = 8'($urandom);
        b.epoch  = $urandom;
        b.now    = $urandom;
        b.op     = op;
        return b;
    endfunction

    task automatic add_entry(input logic [31:0] epoch, input logic [7:0] cmd,
                             input logic [15:0] first, input logic [15:0] second);
        cmd_beat_t b;
        b = random_beat(OP_ADD);
        b.epoch  = epoch;
        b.cmd    = cmd;
        b.first  = first;
        b.second = second;
        send_command(b);
    endtask

    task automatic run_due(input logic [31:0] now);
        cmd_beat_t b;
        b = random_beat(OP_RUN);
        b.now = now;
        send_command(b);
    endtask

    task automatic report_status(input logic [31:0] now, input logic [7:0] mode,
                                 input logic [7:0] len);
        cmd_beat_t b;
        b = random_beat(OP_STATUS);
        b.now  = now;
        b.mode = mode;
        b.len  = len;
        send_command(b);
    endtask

    // sender pause until every predicted beat has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(9))
            0, 1, 2, 3: return CODE_SHOOT;
            4, 5, 6:    return CODE_VIDEO;
            default:    return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic log_mismatch(input string what, input sched_result_t want,
                                input sched_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  expected kind %0d bytes %h %h %h log %h due %b busy %b count %0d last %b",
                     want.kind, want.b0, want.b1, want.b2, want.logv, want.due, want.busy,
                     want.count, want.last);
            $display("  actual   kind %0d bytes %h %h %h log %h due %b busy %b count %0d last %b",
                     got.kind, got.b0, got.b1, got.b2, got.logv, got.due, got.busy,
                     got.count, got.last);
        end
    endtask

    always @(posedge aclk) begin : check_results
        sched_result_t got;
        sched_result_t want;

        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.kind  = m_tuser;
            got.b0    = m_tdata[7:0];
            got.b1    = m_tdata[15:8];
            got.b2    = m_tdata[23:16];
            got.logv  = m_tdata[39:24];
            got.due   = m_tdata[40];
            got.busy  = m_tdata[41];
            got.count = m_tdata[47:42];
            got.last  = m_tlast;
            if (pending_results.size() == 0) begin
                log_mismatch("result beat with nothing expected", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.b0 !== want.b0 || got.b1 !== want.b1 ||
                    got.b2 !== want.b2 || got.logv !== want.logv || got.due !== want.due ||
                    got.busy !== want.busy || got.count !== want.count ||
                    got.last !== want.last)
                    log_mismatch("result beat mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table();
        cmd_beat_t b;
        run_due(32'd0);
        run_due(TIME_MAX);
        report_status(32'd0, 8'd0, 8'd11);
        report_status(TIME_MAX, 8'hFF, 8'hFF);
        b = random_beat(OP_UNUSED);
        send_command(b);
        drain_results();
    endtask

    task automatic test_dispatch_kinds();
        add_entry(32'd0,  CODE_SHOOT, 16'hFFFF, 16'h00FF);
        add_entry(32'd100, CODE_VIDEO, 16'hA55A, 16'hFFFF);
        add_entry(32'd50, 8'hFF, 16'h1234, 16'h5678);
        add_entry(32'd60, 8'h00, 16'h0000, 16'h0000);
        add_entry(TIME_MAX, CODE_SHOOT, 16'h0000, 16'hFF00);
        report_status(32'd49, 8'h01, 8'd20);
        run_due(32'd100);
        // busy now set: due stays low until a long idle status
        add_entry(32'd0, CODE_VIDEO, 16'h00FF, 16'h0000);
        report_status(32'd10, 8'h01, 8'd20);
        report_status(32'd10, 8'd0, 8'd11);
        report_status(32'd10, 8'd0, 8'd12);
        run_due(32'd0);
        run_due(32'hFFFF_FFFE);
        run_due(TIME_MAX);
        report_status(TIME_MAX, 8'd0, 8'hFF);
        drain_results();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH; i++)
            add_entry($urandom, pick_command(), 16'($urandom), 16'($urandom));
        add_entry(32'd0, CODE_SHOOT, 16'hFFFF, 16'hFFFF);
        add_entry(TIME_MAX, CODE_VIDEO, 16'h0000, 16'h0000);
        report_status(32'd0, 8'd0, 8'd12);
        run_due(TIME_MAX);
        report_status(TIME_MAX, 8'd0, 8'd200);
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_stall();
        tx_steady = 1'b1;
        rx_hold_req <= rx_hold_req + 1;
        for (int i = 0; i < 6; i++)
            add_entry(32'(i), pick_command(), 16'($urandom), 16'($urandom));
        run_due(32'd3);
        add_entry(32'd2, CODE_SHOOT, 16'($urandom), 16'($urandom));
        report_status(32'd4, 8'd0, 8'd12);
        run_due(TIME_MAX);
        report_status(32'd0, 8'd0, 8'd12);
        tx_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        cmd_beat_t b;
        int        sent;
        int        pick;

        sent = 0;
        sim_clock = 32'd5000;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 30) begin
                tx_steady = 1'b1;
                rx_steady <= 1'b1;
            end else if (sent == 70) begin
                tx_steady = 1'b0;
                rx_steady <= 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                b = random_beat(OP_ADD);
                b.cmd = pick_command();
                if ($urandom_range(9) != 0) b.epoch = sim_clock + $urandom_range(60);
            end else if (pick < 72) begin
                b = random_beat(OP_RUN);
                sim_clock = sim_clock + $urandom_range(30);
                if ($urandom_range(9) != 0) b.now = sim_clock;
            end else if (pick < 95) begin
                b = random_beat(OP_STATUS);
                if ($urandom_range(9) < 7) begin
                    b.mode = STATUS_IDLE;
                    b.len  = 8'($urandom_range(255, 12));
                end
                if ($urandom_range(3) != 0) b.now = sim_clock;
            end else begin
                b = random_beat(OP_UNUSED);
            end
            send_command(b);
            if (b.op != OP_UNUSED) sent++;
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        table_held = 0;
        table_busy = 1'b0;

        test_empty_table();
        test_dispatch_kinds();
        test_full_table();
        test_output_stall();
        test_random_traffic();

        repeat (60) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
